FILE: design/clamped_bilinear_table_interp_unit_assert.svh
// Assertion macros used by the interpolation unit top level.
`ifndef CLAMPED_BILINEAR_TABLE_INTERP_UNIT_ASSERT_SVH
`define CLAMPED_BILINEAR_TABLE_INTERP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CBTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbti assertion failed");
`define CBTI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbti assertion failed");
`else
`define CBTI_ASSERT_IMP(lbl, ante, cons)
`define CBTI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/cbti_pkg.sv
// Types, constants and helpers for the clamped bilinear table interpolation unit.
package cbti_pkg;

  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF = 32;
  localparam int MIN_COUNT    = 3;
  localparam int PROD_W       = 50;
  localparam int DIVS_W       = 25;

  localparam logic [7:0] ROWS_RST = 8'd71;
  localparam logic [5:0] COLS_RST = 6'd20;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic signed [27:0] Q_SIX = 28'sd393216;

  localparam logic [1:0] PASS_LOW  = 2'd0;
  localparam logic [1:0] PASS_HIGH = 2'd1;
  localparam logic [1:0] PASS_TEMP = 2'd2;

  localparam int F_X0 = 0;
  localparam int F_X1 = 1;
  localparam int F_A  = 2;
  localparam int F_B  = 3;
  localparam int F_C  = 4;
  localparam int F_D  = 5;
  localparam int F_T0 = 6;
  localparam int F_T1 = 7;
  localparam int F_N  = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_SRCH,
    S_R_SRCH,
    S_FETCH,
    S_DIFF,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACC,
    S_DONE
  } cbti_state_t;

  typedef struct packed {
    logic               mode;
    logic [6:0]         row;
    logic [4:0]         col;
    logic signed [23:0] entry_value;
    logic signed [23:0] log_temp;
    logic signed [23:0] log_density;
  } cbti_in_t;

  typedef struct packed {
    logic signed [23:0] log_opacity;
    logic               temp_clamped;
    logic               ratio_clamped;
  } cbti_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dividend;
    logic signed [DIVS_W-1:0] divisor;
  } cbti_div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] quotient;
  } cbti_div_rsp_t;

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] hi_lim;
    logic signed [PROD_W:0] lo_lim;
    hi_lim = (PROD_W+1)'(24'sh7FFFFF);
    lo_lim = -(PROD_W+1)'(24'sh7FFFFF) - (PROD_W+1)'(1);
    if (v > hi_lim) begin
      return 24'sh7FFFFF;
    end else if (v < lo_lim) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

FILE: design/cbti_table_ram.sv
// Opacity table storage: one write port, one registered read port.
module cbti_table_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [23:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [23:0] rdata
);

  logic signed [23:0] mem [DEPTH];
  logic signed [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/cbti_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module cbti_div
  import cbti_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cbti_div_req_t req,
  output cbti_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[PROD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend[PROD_W-1] ? PROD_W'(-req.dividend) : PROD_W'(req.dividend);
      dvs_nxt  = req.divisor[DIVS_W-1] ? DIVS_W'(-req.divisor) : DIVS_W'(req.divisor);
      neg_nxt  = req.dividend[PROD_W-1] ^ req.divisor[DIVS_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVS_W'(trial);
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: design/clamped_bilinear_table_interp_unit.sv
// Top level of the clamped bilinear table interpolation unit.
//
// channel | ports                       | beat
// --------+-----------------------------+-----------------------------------
// input   | in_valid/in_ready/in_data   | table write or interpolation query
// result  | out_valid/out_ready/out_data| one per query, none per write
// config  | cfg_we/cfg_index/cfg_wdata  | register write, no wait
//
// A query runs linear searches of the temperature and R axes, fetches eight entries
// through the single table read port, then makes three interpolation passes through
// the shared serial divider (a pass with an interval of zero width skips it). Reset is
// synchronous; the table is not cleared. A stalled result holds in the output register
// while the next beat is accepted.
module clamped_bilinear_table_interp_unit
  import cbti_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cbti_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cbti_out_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

`include "clamped_bilinear_table_interp_unit_assert.svh"

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  cbti_state_t state_r, state_nxt;
  logic [7:0]         rows_reg_r, rows_reg_nxt;
  logic [5:0]         cols_reg_r, cols_reg_nxt;
  logic [RW-1:0]      rows_eff_r, rows_eff_nxt, rows_eff;
  logic [CW-1:0]      cols_eff_r, cols_eff_nxt, cols_eff;
  logic [RW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic signed [23:0] lt_r, lt_nxt;
  logic signed [27:0] lr_r, lr_nxt;
  logic               tflag_r, tflag_nxt;
  logic               rflag_r, rflag_nxt;
  logic [3:0]         k_r, k_nxt;
  logic signed [23:0] fetch_r [F_N];
  logic signed [23:0] fetch_nxt [F_N];
  logic [1:0]         pass_r, pass_nxt;
  logic signed [23:0] lo_r, lo_nxt;
  logic signed [24:0] dh_r, dh_nxt;
  logic signed [24:0] dx_r, dx_nxt;
  logic signed [24:0] dd_r, dd_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] q_r, q_nxt;
  logic signed [23:0] kmin_r, kmin_nxt;
  logic signed [23:0] kmax_r, kmax_nxt;
  logic signed [23:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  cbti_out_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic signed [23:0] ram_rdata;
  cbti_div_req_t      div_req;
  cbti_div_rsp_t      div_rsp;

  logic signed [27:0] lt_ext, ld_ext, lt_off, rd_ext;
  logic signed [23:0] sel_lo, sel_hi, sel_x, sel_x0, sel_x1;
  logic signed [PROD_W:0] acc_sum;

  cbti_table_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cbti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_reg_r  <= ROWS_RST;
      cols_reg_r  <= COLS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_reg_r  <= rows_reg_nxt;
      cols_reg_r  <= cols_reg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rows_eff_r <= rows_eff_nxt;
    cols_eff_r <= cols_eff_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lt_r       <= lt_nxt;
    lr_r       <= lr_nxt;
    tflag_r    <= tflag_nxt;
    rflag_r    <= rflag_nxt;
    k_r        <= k_nxt;
    fetch_r    <= fetch_nxt;
    pass_r     <= pass_nxt;
    lo_r       <= lo_nxt;
    dh_r       <= dh_nxt;
    dx_r       <= dx_nxt;
    dd_r       <= dd_nxt;
    prod_r     <= prod_nxt;
    q_r        <= q_nxt;
    kmin_r     <= kmin_nxt;
    kmax_r     <= kmax_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    cols_reg_nxt = cols_reg_r;
    rows_reg_nxt = rows_reg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_reg_nxt = cfg_wdata;
        CFG_COLS: cols_reg_nxt = cfg_wdata[5:0];
        default:  rows_reg_nxt = rows_reg_r;
      endcase
    end
  end

  always_comb begin
    if (int'(rows_reg_r) < MIN_COUNT) begin
      rows_eff = RW'(MIN_COUNT);
    end else if (int'(rows_reg_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_reg_r);
    end
    if (int'(cols_reg_r) < MIN_COUNT) begin
      cols_eff = CW'(MIN_COUNT);
    end else if (int'(cols_reg_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_reg_r);
    end
  end

  assign lt_ext = {{4{in_data.log_temp[23]}}, in_data.log_temp};
  assign ld_ext = {{4{in_data.log_density[23]}}, in_data.log_density};
  assign lt_off = lt_ext - Q_SIX;
  assign rd_ext = {{4{ram_rdata[23]}}, ram_rdata};
  assign ram_waddr = AW'(int'(in_data.row) * MAX_COLS + int'(in_data.col));

  always_comb begin
    unique case (pass_r)
      PASS_LOW: begin
        sel_lo = fetch_r[F_A];
        sel_hi = fetch_r[F_B];
        sel_x  = lr_r[23:0];
        sel_x0 = fetch_r[F_X0];
        sel_x1 = fetch_r[F_X1];
      end
      PASS_HIGH: begin
        sel_lo = fetch_r[F_C];
        sel_hi = fetch_r[F_D];
        sel_x  = lr_r[23:0];
        sel_x0 = fetch_r[F_X0];
        sel_x1 = fetch_r[F_X1];
      end
      default: begin
        sel_lo = kmin_r;
        sel_hi = kmax_r;
        sel_x  = lt_r;
        sel_x0 = fetch_r[F_T0];
        sel_x1 = fetch_r[F_T1];
      end
    endcase
  end

  assign acc_sum = (PROD_W+1)'(lo_r) + (PROD_W+1)'(q_r);

  always_comb begin
    state_nxt     = state_r;
    rows_eff_nxt  = rows_eff_r;
    cols_eff_nxt  = cols_eff_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lt_nxt        = lt_r;
    lr_nxt        = lr_r;
    tflag_nxt     = tflag_r;
    rflag_nxt     = rflag_r;
    k_nxt         = k_r;
    fetch_nxt     = fetch_r;
    pass_nxt      = pass_r;
    lo_nxt        = lo_r;
    dh_nxt        = dh_r;
    dx_nxt        = dx_r;
    dd_nxt        = dd_r;
    prod_nxt      = prod_r;
    q_nxt         = q_r;
    kmin_nxt      = kmin_r;
    kmax_nxt      = kmax_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = cell_addr(RW'(1), CW'(0));
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = dd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_WRITE) begin
            ram_we = (int'(in_data.row) < MAX_ROWS) && (int'(in_data.col) < MAX_COLS);
          end else begin
            rows_eff_nxt = rows_eff;
            cols_eff_nxt = cols_eff;
            lt_nxt       = in_data.log_temp;
            lr_nxt       = ld_ext - (lt_off + (lt_off <<< 1));
            tflag_nxt    = 1'b0;
            rflag_nxt    = 1'b0;
            i_nxt        = RW'(1);
            state_nxt    = S_T_SRCH;
          end
        end
      end
      S_T_SRCH: begin
        if (ram_rdata < lt_r && (i_r + RW'(1)) != rows_eff_r) begin
          i_nxt     = i_r + RW'(1);
          ram_raddr = cell_addr(i_r + RW'(1), CW'(0));
        end else begin
          if (ram_rdata < lt_r) begin
            lt_nxt    = ram_rdata;
            tflag_nxt = 1'b1;
          end else if (i_r == RW'(1)) begin
            i_nxt     = RW'(2);
            lt_nxt    = ram_rdata;
            tflag_nxt = ram_rdata != lt_r;
          end
          j_nxt     = CW'(1);
          ram_raddr = cell_addr(RW'(0), CW'(1));
          state_nxt = S_R_SRCH;
        end
      end
      S_R_SRCH: begin
        if (rd_ext < lr_r && (j_r + CW'(1)) != cols_eff_r) begin
          j_nxt     = j_r + CW'(1);
          ram_raddr = cell_addr(RW'(0), j_r + CW'(1));
        end else begin
          if (rd_ext < lr_r) begin
            lr_nxt    = rd_ext;
            rflag_nxt = 1'b1;
          end else if (j_r == CW'(1)) begin
            j_nxt     = CW'(2);
            lr_nxt    = rd_ext;
            rflag_nxt = rd_ext != lr_r;
          end
          k_nxt     = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (k_r)
          4'(F_X0): ram_raddr = cell_addr(RW'(0), CW'(j_r - CW'(1)));
          4'(F_X1): ram_raddr = cell_addr(RW'(0), j_r);
          4'(F_A):  ram_raddr = cell_addr(RW'(i_r - RW'(1)), CW'(j_r - CW'(1)));
          4'(F_B):  ram_raddr = cell_addr(RW'(i_r - RW'(1)), j_r);
          4'(F_C):  ram_raddr = cell_addr(i_r, CW'(j_r - CW'(1)));
          4'(F_D):  ram_raddr = cell_addr(i_r, j_r);
          4'(F_T0): ram_raddr = cell_addr(RW'(i_r - RW'(1)), CW'(0));
          default:  ram_raddr = cell_addr(i_r, CW'(0));
        endcase
        if (k_r != '0) begin
          fetch_nxt[3'(k_r - 4'd1)] = ram_rdata;
        end
        k_nxt = k_r + 4'd1;
        if (k_r == 4'(F_N)) begin
          pass_nxt  = PASS_LOW;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        lo_nxt    = sel_lo;
        dh_nxt    = 25'(sel_hi) - 25'(sel_lo);
        dx_nxt    = 25'(sel_x) - 25'(sel_x0);
        dd_nxt    = 25'(sel_x1) - 25'(sel_x0);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = PROD_W'(dh_r * dx_r);
        if (dd_r == '0) begin
          q_nxt     = '0;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quotient;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        unique case (pass_r)
          PASS_LOW: begin
            kmin_nxt  = sat24(acc_sum);
            pass_nxt  = PASS_HIGH;
            state_nxt = S_DIFF;
          end
          PASS_HIGH: begin
            kmax_nxt  = sat24(acc_sum);
            pass_nxt  = PASS_TEMP;
            state_nxt = S_DIFF;
          end
          default: begin
            res_nxt   = sat24(acc_sum);
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.log_opacity   = res_r;
          out_data_nxt.temp_clamped  = tflag_r;
          out_data_nxt.ratio_clamped = rflag_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CBTI_ASSERT_NXT(a_done_loads, state_r == S_DONE && (!out_valid_r || out_ready), out_valid_r)
  `CBTI_ASSERT_NXT(a_done_idle, state_r == S_DONE && (!out_valid_r || out_ready), in_ready)
  `CBTI_ASSERT_IMP(a_t_bound, state_r == S_T_SRCH, i_r < rows_eff_r && i_r != '0)
  `CBTI_ASSERT_IMP(a_r_bound, state_r == S_R_SRCH, j_r < cols_eff_r && j_r != '0)
  `CBTI_ASSERT_IMP(a_div_done, div_rsp.done, state_r == S_DIV_WAIT)

endmodule

FILE: dv/tb_clamped_bilinear_table_interp_unit.sv
// Self-checking testbench for the clamped bilinear table interpolation unit.
`timescale 1ns / 100ps
module tb_clamped_bilinear_table_interp_unit;
  import cbti_pkg::*;

  localparam int N_ROWS = 128;
  localparam int N_COLS = 32;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int IN_BITS = $bits(cbti_in_t);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  cbti_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  cbti_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_ROWS;
  logic [7:0] cfg_wdata = '0;

  clamped_bilinear_table_interp_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  logic signed [23:0] tbl [N_ROWS][N_COLS];
  logic [7:0] rows_reg;
  logic [5:0] cols_reg;
  cbti_in_t   pending_beats[$];
  cbti_out_t  expected_opacity[$];
  int         err_count = 0;
  int         idle_cycles = 0;
  int         hold_off = 0;
  bit         pause_sender = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic longint sat_q24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint blend(input longint lo, hi, x, x0, x1);
    if (x1 == x0) return lo;
    return lo + ((hi - lo) * (x - x0)) / (x1 - x0);
  endfunction

  function automatic cbti_out_t interpolate(input cbti_in_t b);
    cbti_out_t r;
    int rows, cols, i, j;
    longint lt, lr, k0, k1;
    rows = (rows_reg < 3) ? 3 : (rows_reg > N_ROWS) ? N_ROWS : int'(rows_reg);
    cols = (cols_reg < 3) ? 3 : (cols_reg > N_COLS) ? N_COLS : int'(cols_reg);
    r = '0;
    lt = b.log_temp;
    lr = longint'(b.log_density) - 3 * (lt - 393216);
    i = 1;
    while (i < rows && tbl[i][0] < lt) i++;
    if (i == 1) begin
      r.temp_clamped = lt < tbl[1][0];
      i = 2;
      lt = tbl[1][0];
    end else if (i == rows) begin
      r.temp_clamped = 1'b1;
      i = rows - 1;
      lt = tbl[rows-1][0];
    end
    j = 1;
    while (j < cols && tbl[0][j] < lr) j++;
    if (j == 1) begin
      r.ratio_clamped = lr < tbl[0][1];
      j = 2;
      lr = tbl[0][1];
    end else if (j == cols) begin
      r.ratio_clamped = 1'b1;
      j = cols - 1;
      lr = tbl[0][cols-1];
    end
    k0 = sat_q24(blend(tbl[i-1][j-1], tbl[i-1][j], lr, tbl[0][j-1], tbl[0][j]));
    k1 = sat_q24(blend(tbl[i][j-1], tbl[i][j], lr, tbl[0][j-1], tbl[0][j]));
    r.log_opacity = 24'(sat_q24(blend(k0, k1, lt, tbl[i-1][0], tbl[i][0])));
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 400);
  endfunction

  function automatic cbti_in_t write_beat(input int r, c, input logic signed [23:0] v);
    cbti_in_t b;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    b = cbti_in_t'(raw[IN_BITS-1:0]);
    b.mode = MODE_WRITE;
    b.row = 7'(r);
    b.col = 5'(c);
    b.entry_value = v;
    return b;
  endfunction

  function automatic cbti_in_t query_beat(input logic signed [23:0] t, d);
    cbti_in_t b;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    b = cbti_in_t'(raw[IN_BITS-1:0]);
    b.mode = MODE_QUERY;
    b.log_temp = t;
    b.log_density = d;
    return b;
  endfunction

  // driver
  int   send_gap = 0;
  logic in_taken = 1'b0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() > 0 && !pause_sender) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted-beat bookkeeping at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      if (in_data.mode == MODE_WRITE) begin
        tbl[in_data.row][in_data.col] <= in_data.entry_value;
      end else begin
        expected_opacity.push_back(interpolate(in_data));
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cbti_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_opacity.size() == 0) begin
        report("unexpected beat", 64'(out_data), 64'(0));
      end else begin
        want = expected_opacity.pop_front();
        if (out_data.log_opacity !== want.log_opacity)
          report("log_opacity", 64'(out_data.log_opacity), 64'(want.log_opacity));
        if (out_data.temp_clamped !== want.temp_clamped)
          report("temp_clamped", 64'(out_data.temp_clamped), 64'(want.temp_clamped));
        if (out_data.ratio_clamped !== want.ratio_clamped)
          report("ratio_clamped", 64'(out_data.ratio_clamped), 64'(want.ratio_clamped));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_off <= 3000;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      hold_off <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_opacity.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = v;
    else cols_reg = v[5:0];
  endtask

  // load monotonic axes and a random body over rows x cols
  task automatic load_table(input int rows, cols, input bit extreme);
    int step;
    step = extreme ? 120000 : $urandom_range(1000, 60000);
    for (int r = 1; r < rows; r++)
      pending_beats.push_back(write_beat(r, 0,
        24'(-4000000 + r * step / 2 + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 200)))));
    for (int c = 1; c < cols; c++)
      pending_beats.push_back(write_beat(0, c,
        24'(-8000000 + c * step * 4 + $urandom_range(0, 300))));
    for (int r = 1; r < rows; r++)
      for (int c = 1; c < cols; c++)
        pending_beats.push_back(write_beat(r, c,
          extreme ? (($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000)
                  : 24'($urandom_range(0, 2000000)) - 24'sd1000000));
    pending_beats.push_back(write_beat(0, 0, 24'($urandom)));
  endtask

  function automatic cbti_in_t random_query();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7)
      return query_beat(24'(-4000000 + $urandom_range(0, 4000000)),
                        24'(-8000000 + $urandom_range(0, 16000000)));
    return query_beat(24'($urandom), 24'($urandom));
  endfunction

  initial begin
    rows_reg = ROWS_RST;
    cols_reg = COLS_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // rows above the maximum, columns below the minimum
    set_reg(CFG_ROWS, 8'd255);
    set_reg(CFG_COLS, 8'd0);
    load_table(N_ROWS, 3, 1'b0);
    pending_beats.push_back(query_beat(24'sh800000, 24'sh800000));
    pending_beats.push_back(query_beat(24'sh7FFFFF, 24'sh7FFFFF));
    pending_beats.push_back(query_beat(24'sh7FFFFF, 24'sh800000));
    pending_beats.push_back(query_beat(24'sh800000, 24'sh7FFFFF));
    pending_beats.push_back(query_beat(24'sd0, 24'sd0));
    pending_beats.push_back(query_beat(24'sh7FFFFF, 24'sd0));
    for (int k = 0; k < 10; k++) pending_beats.push_back(random_query());
    wait_drained();

    // rows below the minimum, columns above the maximum
    set_reg(CFG_ROWS, 8'd0);
    set_reg(CFG_COLS, 8'd63);
    load_table(3, N_COLS, 1'b0);
    for (int k = 0; k < 10; k++) pending_beats.push_back(random_query());
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      set_reg(CFG_ROWS, 8'($urandom_range(3, 10)));
      set_reg(CFG_COLS, 8'($urandom_range(3, 10)));
      if (phase == 2) load_table(10, 10, 1'b1);
      else if (phase == 0 || phase == 4) load_table(10, 10, 1'b0);
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 9) == 0)
          pending_beats.push_back(write_beat($urandom_range(1, 9), $urandom_range(1, 9),
                                             24'($urandom_range(0, 2000000)) - 24'sd1000000));
        else pending_beats.push_back(random_query());
      end
      if (phase == 1) long_hold_req = 1'b1;
      while (pending_beats.size() > 20) @(posedge clk);
      if (phase == 3) begin
        pause_sender = 1'b1;
        while (expected_opacity.size() > 0 || in_valid) @(posedge clk);
        pause_sender = 1'b0;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cbti_pkg.sv
design/cbti_table_ram.sv
design/cbti_div.sv
design/clamped_bilinear_table_interp_unit.sv
dv/tb_clamped_bilinear_table_interp_unit.sv
